[design/gjk_pkg.sv]
// Shared types, widths and codes for the convex polygon overlap unit.
// Used by every module of the unit; depends on nothing else.
package gjk_pkg;

   // Coordinate width of a vertex (signed Q8.8).
   localparam int COORD_BITS = 16;
   // Packed vertex: x in the upper half, z in the lower half.
   localparam int VTX_W = 2 * COORD_BITS;
   // Minkowski difference point, search direction and edge vectors.
   localparam int PT_W = COORD_BITS + 1;
   localparam int DIR_W = COORD_BITS + 2;
   // Vertex dot direction inside the support search.
   localparam int PROD_W = COORD_BITS + DIR_W;
   localparam int DOT_W = PROD_W + 1;
   // Products and differences of the simplex arithmetic.
   localparam int WMUL_W = 2 * DIR_W;
   localparam int DIFF_W = WMUL_W + 1;

   localparam int DEF_MAX_VERTICES = 64;

   // Request codes.
   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_RUN = 2'd2;

   // Result status codes.
   localparam logic [2:0] STAT_APART = 3'd0;
   localparam logic [2:0] STAT_HIT = 3'd1;
   localparam logic [2:0] STAT_LIMIT = 3'd2;
   localparam logic [2:0] STAT_EMPTY = 3'd3;
   localparam logic [2:0] STAT_OVERFLOW = 3'd4;

   // Configuration register addresses and reset value.
   localparam logic [0:0] REG_ITER_LIMIT = 1'b0;
   localparam logic [7:0] ITER_LIMIT_RESET = 8'd32;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic signed [COORD_BITS-1:0] vertex_x;
      logic signed [COORD_BITS-1:0] vertex_z;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] passes_used;
   } rsp_payload_type;

   // Sweep control from the sequencer to a support search unit.
   typedef struct packed {
      logic start;
      logic rd_valid;
   } sweep_ctl_type;

endpackage

[design/gjk_convex_polygon_overlap_unit.sv]
// Convex polygon overlap unit (2D GJK). Each pass of a run sweeps both vertex
// memories up to the larger vertex count, through the one read port of each.
// One item is in work at a time; a finished result waits in an output register.
// Synchronous reset clears counts, flags and the limit (to 32); memories keep data.
module gjk_convex_polygon_overlap_unit #(
   parameter int MAX_VERTICES = gjk_pkg::DEF_MAX_VERTICES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  gjk_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output gjk_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [0:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import gjk_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SWEEP = 4'd1;
   localparam logic [3:0] ST_DRAIN = 4'd2;
   localparam logic [3:0] ST_SUP = 4'd3;
   localparam logic [3:0] ST_CHECK = 4'd4;
   localparam logic [3:0] ST_DOT = 4'd5;
   localparam logic [3:0] ST_TEST = 4'd6;
   localparam logic [3:0] ST_M1 = 4'd7;
   localparam logic [3:0] ST_M2 = 4'd8;
   localparam logic [3:0] ST_M3 = 4'd9;
   localparam logic [3:0] ST_LINE = 4'd10;
   localparam logic [3:0] ST_TRI = 4'd11;
   localparam logic [3:0] ST_DONE = 4'd12;

   // Control registers.
   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             init_ff, init_in;
   logic [1:0]       sz_ff, sz_in;
   logic [7:0]       passes_ff, passes_in;
   logic [7:0]       limit_ff, limit_in;
   logic             overflow_ff, overflow_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       status_ff, status_in;

   // Datapath registers.
   logic signed [DIR_W-1:0] dir_x_ff, dir_x_in, dir_z_ff, dir_z_in;
   logic signed [PT_W-1:0]  p_x_ff, p_x_in, p_z_ff, p_z_in;
   logic signed [PT_W-1:0]  s0_x_ff, s0_x_in, s0_z_ff, s0_z_in;
   logic signed [PT_W-1:0]  s1_x_ff, s1_x_in, s1_z_ff, s1_z_in;
   logic signed [DIR_W-1:0] ab_x_ff, ab_x_in, ab_z_ff, ab_z_in;
   logic signed [DIR_W-1:0] ac_x_ff, ac_x_in, ac_z_ff, ac_z_in;
   logic signed [WMUL_W-1:0] m1_ff, m1_in, m2_ff, m2_in, m3_ff, m3_in;
   logic signed [WMUL_W-1:0] m4_ff, m4_in, m5_ff, m5_in, m6_ff, m6_in;
   logic signed [DIFF_W-1:0] diff_ab_ff, diff_ab_in, diff_k_ff, diff_k_in;
   rsp_payload_type rsp_data_ff;

   // Combinational helpers.
   logic req_acc;
   logic csr_write;
   logic sweep_start;
   logic rd_en;
   logic out_load;
   logic clear_stores;
   logic signed [DIFF_W-1:0] dot_sum;
   logic signed [DIFF_W-1:0] line_cr;
   logic signed [DIFF_W-1:0] diff_ac;
   logic signed [DIR_W-1:0]  nd_x, nd_z;
   logic signed [PT_W-1:0]   sup_x, sup_z;
   logic k_pos, k_neg, cond_ab, cond_ac;
   logic [CNT_W-1:0] maxcnt;
   logic [CNT_W-1:0] last_idx;

   // Vertex stores and support searches.
   logic [VTX_W-1:0] a_rd_data, b_rd_data;
   logic             a_rd_valid, b_rd_valid;
   logic [CNT_W-1:0] count_a, count_b;
   logic             a_full, b_full;
   logic             a_busy, b_busy;
   coord_type        a_best_x, a_best_z, b_best_x, b_best_z;
   sweep_ctl_type    a_ctl, b_ctl;

   assign req_acc = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);

   gjk_vstore #(.MAX_VERTICES(MAX_VERTICES)) u_store_a (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_acc && (req_data.req_type == REQ_LOAD_A)),
      .wr_data  ({req_data.vertex_x, req_data.vertex_z}),
      .clear    (clear_stores),
      .rd_en    (rd_en),
      .rd_addr  (idx_ff[IDX_W-1:0]),
      .rd_data  (a_rd_data),
      .rd_valid (a_rd_valid),
      .count    (count_a),
      .full     (a_full)
   );

   gjk_vstore #(.MAX_VERTICES(MAX_VERTICES)) u_store_b (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_acc && (req_data.req_type == REQ_LOAD_B)),
      .wr_data  ({req_data.vertex_x, req_data.vertex_z}),
      .clear    (clear_stores),
      .rd_en    (rd_en),
      .rd_addr  (idx_ff[IDX_W-1:0]),
      .rd_data  (b_rd_data),
      .rd_valid (b_rd_valid),
      .count    (count_b),
      .full     (b_full)
   );

   assign a_ctl = '{start: sweep_start, rd_valid: a_rd_valid};
   assign b_ctl = '{start: sweep_start, rd_valid: b_rd_valid};

   gjk_farthest #(.MINIMISE(1'b0)) u_far_a (
      .clock   (clock),
      .reset   (reset),
      .ctl     (a_ctl),
      .rd_data (a_rd_data),
      .dir_x   (dir_x_ff),
      .dir_z   (dir_z_ff),
      .best_x  (a_best_x),
      .best_z  (a_best_z),
      .busy    (a_busy)
   );

   // Farthest along the negated direction is the strict minimum along it.
   gjk_farthest #(.MINIMISE(1'b1)) u_far_b (
      .clock   (clock),
      .reset   (reset),
      .ctl     (b_ctl),
      .rd_data (b_rd_data),
      .dir_x   (dir_x_ff),
      .dir_z   (dir_z_ff),
      .best_x  (b_best_x),
      .best_z  (b_best_z),
      .busy    (b_busy)
   );

   // Configuration port: one register, writes take effect at the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr == REG_ITER_LIMIT);
   assign csr_prdata = (csr_paddr == REG_ITER_LIMIT) ? {24'd0, limit_ff} : 32'd0;
   assign limit_in = csr_write ? csr_pwdata[7:0] : limit_ff;

   // Sweep bounds over the larger of the two stores.
   assign maxcnt = (count_a > count_b) ? count_a : count_b;
   assign last_idx = maxcnt - 1'b1;

   // Support point and simplex arithmetic from registered operands.
   assign sup_x = PT_W'(a_best_x) - PT_W'(b_best_x);
   assign sup_z = PT_W'(a_best_z) - PT_W'(b_best_z);
   assign dot_sum = DIFF_W'(m1_ff) + DIFF_W'(m2_ff);
   assign line_cr = DIFF_W'(m2_ff) - DIFF_W'(m1_ff);
   assign diff_ac = DIFF_W'(m5_ff) - DIFF_W'(m6_ff);
   assign k_pos = (diff_k_ff > 0);
   assign k_neg = (diff_k_ff < 0);
   assign cond_ab = (k_pos && (diff_ab_ff > 0)) || (k_neg && (diff_ab_ff < 0));
   assign cond_ac = (k_pos && (diff_ac > 0)) || (k_neg && (diff_ac < 0));

   // Run sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      init_in = init_ff;
      sz_in = sz_ff;
      passes_in = passes_ff;
      overflow_in = overflow_ff;
      status_in = status_ff;
      dir_x_in = dir_x_ff;
      dir_z_in = dir_z_ff;
      p_x_in = p_x_ff;
      p_z_in = p_z_ff;
      s0_x_in = s0_x_ff;
      s0_z_in = s0_z_ff;
      s1_x_in = s1_x_ff;
      s1_z_in = s1_z_ff;
      ab_x_in = ab_x_ff;
      ab_z_in = ab_z_ff;
      ac_x_in = ac_x_ff;
      ac_z_in = ac_z_ff;
      m1_in = m1_ff;
      m2_in = m2_ff;
      m3_in = m3_ff;
      m4_in = m4_ff;
      m5_in = m5_ff;
      m6_in = m6_ff;
      diff_ab_in = diff_ab_ff;
      diff_k_in = diff_k_ff;
      nd_x = '0;
      nd_z = '0;
      sweep_start = 1'b0;
      rd_en = 1'b0;
      out_load = 1'b0;
      clear_stores = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // Loads into a full store only mark the overflow.
            if (req_acc && (req_data.req_type == REQ_LOAD_A) && a_full) begin
               overflow_in = 1'b1;
            end
            if (req_acc && (req_data.req_type == REQ_LOAD_B) && b_full) begin
               overflow_in = 1'b1;
            end
            if (req_acc && (req_data.req_type == REQ_RUN)) begin
               passes_in = '0;
               if (overflow_ff) begin
                  status_in = STAT_OVERFLOW;
                  state_in = ST_DONE;
               end else if ((count_a == '0) || (count_b == '0)) begin
                  status_in = STAT_EMPTY;
                  state_in = ST_DONE;
               end else begin
                  init_in = 1'b1;
                  dir_x_in = DIR_W'(1);
                  dir_z_in = '0;
                  idx_in = '0;
                  sweep_start = 1'b1;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            rd_en = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!a_rd_valid && !b_rd_valid && !a_busy && !b_busy) begin
               state_in = ST_SUP;
            end
         end
         ST_SUP: begin
            p_x_in = sup_x;
            p_z_in = sup_z;
            if (init_ff) begin
               // The first support point seeds the simplex; search back along -x.
               s0_x_in = sup_x;
               s0_z_in = sup_z;
               sz_in = 2'd1;
               init_in = 1'b0;
               dir_x_in = -DIR_W'(1);
               dir_z_in = '0;
               state_in = ST_CHECK;
            end else begin
               state_in = ST_DOT;
            end
         end
         ST_CHECK: begin
            if (passes_ff >= limit_ff) begin
               status_in = STAT_LIMIT;
               state_in = ST_DONE;
            end else begin
               passes_in = passes_ff + 8'd1;
               idx_in = '0;
               sweep_start = 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_DOT: begin
            m1_in = p_x_ff * dir_x_ff;
            m2_in = p_z_ff * dir_z_ff;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            // A new point that does not pass the origin separates the shapes.
            if (dot_sum < 0) begin
               status_in = STAT_APART;
               state_in = ST_DONE;
            end else begin
               sz_in = sz_ff + 2'd1;
               ab_x_in = DIR_W'(s0_x_ff) - DIR_W'(p_x_ff);
               ab_z_in = DIR_W'(s0_z_ff) - DIR_W'(p_z_ff);
               ac_x_in = DIR_W'(s1_x_ff) - DIR_W'(p_x_ff);
               ac_z_in = DIR_W'(s1_z_ff) - DIR_W'(p_z_ff);
               if (sz_ff == 2'd1) begin
                  s1_x_in = p_x_ff;
                  s1_z_in = p_z_ff;
               end
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            m1_in = ab_z_ff * p_x_ff;
            m2_in = ab_x_ff * p_z_ff;
            state_in = (sz_ff == 2'd2) ? ST_LINE : ST_M2;
         end
         ST_M2: begin
            m3_in = ac_z_ff * ab_x_ff;
            m4_in = ac_x_ff * ab_z_ff;
            diff_ab_in = line_cr;
            state_in = ST_M3;
         end
         ST_M3: begin
            m5_in = ac_z_ff * p_x_ff;
            m6_in = ac_x_ff * p_z_ff;
            diff_k_in = DIFF_W'(m3_ff) - DIFF_W'(m4_ff);
            state_in = ST_TRI;
         end
         ST_LINE: begin
            // Perpendicular to the edge, on the side of the origin.
            if (line_cr > 0) begin
               nd_x = ab_z_ff;
               nd_z = -ab_x_ff;
            end else if (line_cr < 0) begin
               nd_x = -ab_z_ff;
               nd_z = ab_x_ff;
            end
            dir_x_in = nd_x;
            dir_z_in = nd_z;
            if ((nd_x == '0) && (nd_z == '0)) begin
               status_in = STAT_HIT;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_TRI: begin
            // Keep the edge whose outward normal faces the origin, else enclosed.
            if (cond_ab) begin
               s1_x_in = p_x_ff;
               s1_z_in = p_z_ff;
               sz_in = 2'd2;
               nd_x = k_pos ? ab_z_ff : -ab_z_ff;
               nd_z = k_pos ? -ab_x_ff : ab_x_ff;
            end else if (cond_ac) begin
               s0_x_in = s1_x_ff;
               s0_z_in = s1_z_ff;
               s1_x_in = p_x_ff;
               s1_z_in = p_z_ff;
               sz_in = 2'd2;
               nd_x = k_pos ? -ac_z_ff : ac_z_ff;
               nd_z = k_pos ? ac_x_ff : -ac_x_ff;
            end
            dir_x_in = nd_x;
            dir_z_in = nd_z;
            if ((!cond_ab && !cond_ac) || ((nd_x == '0) && (nd_z == '0))) begin
               status_in = STAT_HIT;
               state_in = ST_DONE;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            // Hand the item over once the output register is free; clear stores.
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               clear_stores = 1'b1;
               overflow_in = 1'b0;
               sz_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         init_ff <= 1'b0;
         sz_ff <= '0;
         passes_ff <= '0;
         limit_ff <= ITER_LIMIT_RESET;
         overflow_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff <= STAT_APART;
         dir_x_ff <= DIR_W'(1);
         dir_z_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         init_ff <= init_in;
         sz_ff <= sz_in;
         passes_ff <= passes_in;
         limit_ff <= limit_in;
         overflow_ff <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff <= status_in;
         dir_x_ff <= dir_x_in;
         dir_z_ff <= dir_z_in;
      end
   end

   always_ff @(posedge clock) begin
      p_x_ff <= p_x_in;
      p_z_ff <= p_z_in;
      s0_x_ff <= s0_x_in;
      s0_z_ff <= s0_z_in;
      s1_x_ff <= s1_x_in;
      s1_z_ff <= s1_z_in;
      ab_x_ff <= ab_x_in;
      ab_z_ff <= ab_z_in;
      ac_x_ff <= ac_x_in;
      ac_z_ff <= ac_z_in;
      m1_ff <= m1_in;
      m2_ff <= m2_in;
      m3_ff <= m3_in;
      m4_ff <= m4_in;
      m5_ff <= m5_in;
      m6_ff <= m6_in;
      diff_ab_ff <= diff_ab_in;
      diff_k_ff <= diff_k_in;
      if (out_load) begin
         rsp_data_ff <= '{status: status_ff, passes_used: passes_ff};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // The sweep address never runs past the larger store.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (idx_ff < maxcnt))
      else $error("sweep index beyond vertex count");

   // The line case sees two points, the triangle case three.
   a_line_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LINE) |-> (sz_ff == 2'd2))
      else $error("line case without two points");

   a_tri_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRI) |-> (sz_ff == 2'd3))
      else $error("triangle case without three points");

   // A sweep never starts beyond the pass limit.
   a_pass_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (passes_ff <= limit_ff))
      else $error("pass count above the limit");

   // A finished run is presented at the next edge.
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("result not presented after run");

endmodule

[design/gjk_vstore.sv]
// Vertex store for one polygon: a memory with one write port, one read port and a fill count.
// Depends on gjk_pkg.
module gjk_vstore #(
   parameter int MAX_VERTICES = gjk_pkg::DEF_MAX_VERTICES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [gjk_pkg::VTX_W-1:0] wr_data,
   input  logic                     clear,
   input  logic                     rd_en,
   input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
   output logic [gjk_pkg::VTX_W-1:0] rd_data,
   output logic                     rd_valid,
   output logic [$clog2(MAX_VERTICES+1)-1:0] count,
   output logic                     full
);
   import gjk_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   logic [VTX_W-1:0] mem [MAX_VERTICES];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rd_valid_ff;
   logic [VTX_W-1:0] rd_data_ff;

   assign full = (count_ff == CNT_W'(MAX_VERTICES));

   // Fill count: a store that is full drops further vertices.
   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (wr_en && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_valid_ff <= rd_en && (CNT_W'(rd_addr) < count_ff);
      end
   end

   // Memory write at the fill position and registered read.
   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem[count_ff[IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign rd_valid = rd_valid_ff;
   assign count = count_ff;

endmodule

[design/gjk_farthest.sv]
// Support search for one polygon: multiplies each read vertex by the direction
// and keeps the first vertex with the strict extreme dot product. Uses gjk_pkg.
module gjk_farthest #(
   parameter bit MINIMISE = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gjk_pkg::sweep_ctl_type    ctl,
   input  logic [gjk_pkg::VTX_W-1:0] rd_data,
   input  logic signed [gjk_pkg::DIR_W-1:0] dir_x,
   input  logic signed [gjk_pkg::DIR_W-1:0] dir_z,
   output gjk_pkg::coord_type        best_x,
   output gjk_pkg::coord_type        best_z,
   output logic                      busy
);
   import gjk_pkg::*;

   coord_type vx;
   coord_type vz;
   logic signed [PROD_W-1:0] prod_x_in;
   logic signed [PROD_W-1:0] prod_z_in;
   logic signed [PROD_W-1:0] prod_x_ff;
   logic signed [PROD_W-1:0] prod_z_ff;
   coord_type cand_x_ff;
   coord_type cand_z_ff;
   logic      cand_valid_ff;
   logic      first_ff;
   logic signed [DOT_W-1:0] dot;
   logic signed [DOT_W-1:0] best_dot_ff;
   coord_type best_x_ff;
   coord_type best_z_ff;
   logic      take;

   assign vx = rd_data[VTX_W-1:COORD_BITS];
   assign vz = rd_data[COORD_BITS-1:0];

   // First stage: the two products of the dot product.
   assign prod_x_in = vx * dir_x;
   assign prod_z_in = vz * dir_z;

   // Second stage: sum and compare against the best so far.
   assign dot = DOT_W'(prod_x_ff) + DOT_W'(prod_z_ff);
   assign take = cand_valid_ff &&
                 (first_ff || (MINIMISE ? (dot < best_dot_ff) : (dot > best_dot_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         cand_valid_ff <= ctl.rd_valid;
         if (ctl.start) begin
            first_ff <= 1'b1;
         end else if (take) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_z_ff <= prod_z_in;
      cand_x_ff <= vx;
      cand_z_ff <= vz;
      if (take) begin
         best_dot_ff <= dot;
         best_x_ff <= cand_x_ff;
         best_z_ff <= cand_z_ff;
      end
   end

   assign best_x = best_x_ff;
   assign best_z = best_z_ff;
   assign busy = cand_valid_ff;

endmodule

[test/tb.sv]
// Testbench for the convex polygon overlap unit: loads random and directed
// polygons, runs 2D GJK tests and checks each status and pass count against a local predictor.
// Depends on gjk_pkg and gjk_convex_polygon_overlap_unit.
`timescale 1ns / 100ps

class overlap_scoreboard;
   gjk_pkg::rsp_payload_type pending_results[$];
   logic signed [15:0] poly_a_x[64], poly_a_z[64], poly_b_x[64], poly_b_z[64];
   int unsigned cnt_a, cnt_b;
   bit overflowed;
   int unsigned pass_limit;
   int unsigned mismatches;

   function void clear_all();
      cnt_a = 0;
      cnt_b = 0;
      overflowed = 0;
      pass_limit = 32;
      pending_results.delete();
   endfunction

   // Appends a predicted result item at the tail of the queue.
   function void enqueue_result(gjk_pkg::rsp_payload_type res);
      pending_results = {pending_results, res};
   endfunction

   // Farthest vertex of one polygon along a direction; first strict maximum wins.
   function void farthest_vertex(bit use_b, longint dx, longint dz,
                                 output longint px, output longint pz);
      longint best, dp, x, z;
      int unsigned n;
      n = use_b ? cnt_b : cnt_a;
      px = use_b ? poly_b_x[0] : poly_a_x[0];
      pz = use_b ? poly_b_z[0] : poly_a_z[0];
      best = px * dx + pz * dz;
      for (int i = 1; i < n; i++) begin
         x = use_b ? poly_b_x[i] : poly_a_x[i];
         z = use_b ? poly_b_z[i] : poly_a_z[i];
         dp = x * dx + z * dz;
         if (dp > best) begin
            best = dp;
            px = x;
            pz = z;
         end
      end
   endfunction

   function void minkowski_support(longint dx, longint dz, output longint sx,
                                   output longint sz);
      longint ax, az, bx, bz;
      farthest_vertex(0, dx, dz, ax, az);
      farthest_vertex(1, -dx, -dz, bx, bz);
      sx = ax - bx;
      sz = az - bz;
   endfunction

   function longint sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function logic [2:0] gjk_status(output int unsigned passes);
      longint spx[3], spz[3];
      int unsigned ssize;
      longint dx, dz, px, pz, ax, az, abx, abz, acx, acz, k, s;
      longint abpx, abpz, acpx, acpz;
      passes = 0;
      minkowski_support(1, 0, px, pz);
      spx[0] = px;
      spz[0] = pz;
      ssize = 1;
      dx = -1;
      dz = 0;
      forever begin
         if (passes >= pass_limit) return gjk_pkg::STAT_LIMIT;
         passes++;
         minkowski_support(dx, dz, px, pz);
         spx[ssize] = px;
         spz[ssize] = pz;
         ssize++;
         if (px * dx + pz * dz < 0) return gjk_pkg::STAT_APART;
         ax = spx[ssize-1];
         az = spz[ssize-1];
         abx = spx[0] - ax;
         abz = spz[0] - az;
         if (ssize == 2) begin
            s = sign_of(abz * -ax - abx * -az);
            dx = s * abz;
            dz = -s * abx;
         end else begin
            acx = spx[1] - ax;
            acz = spz[1] - az;
            k = sign_of(acz * abx - acx * abz);
            abpx = k * abz;
            abpz = -k * abx;
            acpx = -k * acz;
            acpz = k * acx;
            if (abpx * -ax + abpz * -az > 0) begin
               spx[1] = spx[2];
               spz[1] = spz[2];
               ssize = 2;
               dx = abpx;
               dz = abpz;
            end else if (acpx * -ax + acpz * -az > 0) begin
               spx[0] = spx[1];
               spz[0] = spz[1];
               spx[1] = spx[2];
               spz[1] = spz[2];
               ssize = 2;
               dx = acpx;
               dz = acpz;
            end else begin
               return gjk_pkg::STAT_HIT;
            end
         end
         if (dx == 0 && dz == 0) return gjk_pkg::STAT_HIT;
      end
   endfunction

   // Notes an accepted request item and predicts its result, if any.
   function void note_request(gjk_pkg::req_payload_type item);
      gjk_pkg::rsp_payload_type res;
      int unsigned passes;
      passes = 0;
      case (item.req_type)
         gjk_pkg::REQ_LOAD_A: begin
            if (cnt_a >= 64) overflowed = 1;
            else begin
               poly_a_x[cnt_a] = item.vertex_x;
               poly_a_z[cnt_a] = item.vertex_z;
               cnt_a++;
            end
         end
         gjk_pkg::REQ_LOAD_B: begin
            if (cnt_b >= 64) overflowed = 1;
            else begin
               poly_b_x[cnt_b] = item.vertex_x;
               poly_b_z[cnt_b] = item.vertex_z;
               cnt_b++;
            end
         end
         gjk_pkg::REQ_RUN: begin
            if (overflowed) res.status = gjk_pkg::STAT_OVERFLOW;
            else if (cnt_a == 0 || cnt_b == 0) res.status = gjk_pkg::STAT_EMPTY;
            else res.status = gjk_status(passes);
            res.passes_used = passes[7:0];
            enqueue_result(res);
            cnt_a = 0;
            cnt_b = 0;
            overflowed = 0;
         end
         default: ;
      endcase
   endfunction

   task report(string what, int unsigned got, int unsigned want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Compares a result item with the oldest prediction.
   task check_result(gjk_pkg::rsp_payload_type got);
      gjk_pkg::rsp_payload_type want;
      if (pending_results.size() == 0) begin
         report("unexpected result", 1, 0);
         return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.passes_used !== want.passes_used)
         report("passes_used", got.passes_used, want.passes_used);
   endtask
endclass

module tb;
   import gjk_pkg::*;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_payload_type req_data;
   rsp_payload_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [0:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   overlap_scoreboard board;
   int unsigned quiet_cycles;
   int unsigned hold_off;
   bit hold_req, hold_armed;
   bit calm_sender, calm_receiver;

   gjk_convex_polygon_overlap_unit dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Result side: random stalls, a long hold-off on request, and checking.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         hold_off <= 0;
         hold_armed <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         hold_armed <= hold_req;
         if (hold_req && !hold_armed) begin
            hold_off <= 300;
            rsp_stall <= 1;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1;
         end else rsp_stall <= !calm_receiver && ($urandom_range(99) < 10);
      end
   end

   // Watchdog on cycles where neither channel moves an item.
   always @(posedge clock) begin
      if (reset) quiet_cycles <= 0;
      else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 400000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Offers one item; valid stays high afterwards until the next item or a drain.
   task automatic send_item(logic [1:0] kind, logic [15:0] x, logic [15:0] z);
      while (!calm_sender && $urandom_range(99) < 10) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{req_type: kind, vertex_x: x, vertex_z: z};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request('{req_type: kind, vertex_x: x, vertex_z: z});
   endtask

   task automatic write_limit(logic [7:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= REG_ITER_LIMIT;
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      board.pass_limit = value;
   endtask

   // Stops offering, waits for every predicted result, then lets the block settle.
   task automatic drain();
      req_valid <= 0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Random convex-ish polygon: points on a rough circle around a centre.
   task automatic send_polygon(logic [1:0] kind, int cx, int cz, int radius, int n);
      real ang;
      int px, pz;
      for (int i = 0; i < n; i++) begin
         ang = 6.2831853 * i / n;
         px = cx + $rtoi(radius * $cos(ang));
         pz = cz + $rtoi(radius * $sin(ang));
         send_item(kind, px[15:0], pz[15:0]);
      end
   endtask

   task automatic random_test();
      int r, cxa, cza, cxb, czb, na, nb;
      r = $urandom_range(99);
      na = $urandom_range(1, 8);
      nb = $urandom_range(1, 8);
      cxa = $urandom_range(4000) - 2000;
      cza = $urandom_range(4000) - 2000;
      cxb = cxa + $urandom_range(2000) - 1000;
      czb = cza + $urandom_range(2000) - 1000;
      if (r < 75) begin
         send_polygon(REQ_LOAD_A, cxa, cza, $urandom_range(20, 800), na);
         send_polygon(REQ_LOAD_B, cxb, czb, $urandom_range(20, 800), nb);
      end else begin
         repeat (na) send_item(2'($urandom_range(3)), 16'($urandom), 16'($urandom));
      end
      send_item(REQ_RUN, 16'($urandom), 16'($urandom));
   endtask

   initial begin
      board = new();
      board.clear_all();
      board.mismatches = 0;
      hold_req = 0;
      calm_sender = 0;
      calm_receiver = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed, at the reset limit: empty shapes, extremes, an unused code.
      send_item(REQ_RUN, 0, 0);
      send_item(REQ_LOAD_A, 16'h7fff, 16'h8000);
      send_item(REQ_RUN, 0, 0);
      send_item(REQ_LOAD_A, 16'h7fff, 16'h7fff);
      send_item(REQ_LOAD_A, 16'h8000, 16'h8000);
      send_item(REQ_LOAD_A, 16'h8000, 16'h7fff);
      send_item(REQ_LOAD_B, 16'h7fff, 16'h8000);
      send_item(2'd3, 16'hffff, 16'hffff);
      send_item(REQ_LOAD_B, 16'hffff, 16'h0000);
      send_item(REQ_RUN, 0, 0);
      send_item(REQ_LOAD_A, 0, 0);
      send_item(REQ_LOAD_B, 0, 0);
      send_item(REQ_RUN, 0, 0);
      send_item(REQ_LOAD_A, 16'd100, 0);
      send_item(REQ_LOAD_B, 16'hff00, 0);
      send_item(REQ_RUN, 0, 0);
      drain();

      // A store filled beyond its capacity reports overflow.
      calm_sender = 1;
      repeat (66) send_item(REQ_LOAD_B, 16'($urandom), 16'($urandom));
      send_item(REQ_LOAD_A, 1, 1);
      send_item(REQ_RUN, 0, 0);
      calm_sender = 0;
      drain();

      // Limit extremes: zero, one, the maximum.
      write_limit(8'd0);
      send_polygon(REQ_LOAD_A, 0, 0, 300, 5);
      send_polygon(REQ_LOAD_B, 100, 50, 300, 4);
      send_item(REQ_RUN, 0, 0);
      drain();
      write_limit(8'd1);
      repeat (5) random_test();
      drain();
      write_limit(8'd255);
      repeat (6) random_test();
      drain();

      // Long receiver hold-off while the sender keeps offering items.
      hold_req = 1;
      repeat (4) random_test();
      drain();

      write_limit(8'd3);
      repeat (4) random_test();
      drain();

      // A stretch with no idling on either side.
      calm_sender = 1;
      calm_receiver = 1;
      write_limit(8'd32);
      repeat (10) random_test();
      drain();
      calm_sender = 0;
      calm_receiver = 0;

      write_limit(8'($urandom_range(2, 254)));
      repeat (6) random_test();
      drain();
      repeat (200) @(posedge clock);

      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
